// ===== design/laplacian_edge_3x3_core_macros.svh =====
// assertion macros shared by the laplacian edge filter
`ifndef LAPLACIAN_EDGE_3X3_CORE_MACROS_SVH
`define LAPLACIAN_EDGE_3X3_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define LEC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define LEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lec_pkg.sv =====
// shared types and constants of the laplacian edge filter
package lec_pkg;

  localparam int PIX_W        = 8;
  localparam int ROW_OUT_W    = 12;
  localparam int COL_OUT_W    = 10;
  localparam int SUM_W        = 12;
  localparam int MASK_W       = 2;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int TAPS         = 9;
  localparam int NUM_MASKS    = 4;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam logic [CFG_INDEX_W-1:0] REG_MASK   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;

  // mask codes
  localparam logic [MASK_W-1:0] MASK_FOUR     = 2'd0;
  localparam logic [MASK_W-1:0] MASK_FOUR_NEG = 2'd1;
  localparam logic [MASK_W-1:0] MASK_EIGHT    = 2'd2;
  localparam logic [MASK_W-1:0] MASK_DIAG     = 2'd3;

  typedef logic signed [4:0] weight_t;

  // row-major taps: top row first, left column first
  localparam weight_t LAP_WEIGHTS [NUM_MASKS][TAPS] = '{
    '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd4, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
    '{ 5'sd0,  5'sd1,  5'sd0,  5'sd1, -5'sd4,  5'sd1,  5'sd0,  5'sd1,  5'sd0},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{ 5'sd1, -5'sd2,  5'sd1, -5'sd2,  5'sd4, -5'sd2,  5'sd1, -5'sd2,  5'sd1}
  };

  typedef struct packed {
    logic                 last;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
  } tag_t;

endpackage

// ===== design/laplacian_edge_3x3_core.sv =====
// top level of the streaming 3x3 laplacian edge filter
// usage:
//   pixels enter in raster order on pixel / pixel_valid / pixel_ready, one item
//   per cycle when the output side keeps up
//   each interior centre pixel leaves on edge_value, center_row, center_col and
//   frame_last under result_valid / result_ready; border pixels give no item
//   cfg_valid / cfg_index / cfg_data write mask_select (0), image_width (1) and
//   image_height (2); cfg_ready is always high, index 3 is ignored
//   a size write restarts the frame at row 0, column 0
//   a result passes the store, sum and output stages after the pixel that
//   completes its window is accepted; throughput is one item per cycle while
//   the output keeps up, set by the single read port and single write port of
//   the line store (one read-modify-write of a column entry per pixel)
//   reset: counters to zero, mask 0, size 640 x 480, window cleared; the line
//   store is not cleared and needs no clearing pass
//   when the receiver stalls the output register holds, the sum stage and the
//   store stage fill, then pixel_ready drops; nothing is lost
`include "laplacian_edge_3x3_core_macros.svh"
module laplacian_edge_3x3_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  // pixel input
  input  logic                                pixel_valid,
  output logic                                pixel_ready,
  input  logic [lec_pkg::PIX_W-1:0]           pixel,
  // result output
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [lec_pkg::PIX_W-1:0]           edge_value,
  output logic [lec_pkg::ROW_OUT_W-1:0]       center_row,
  output logic [lec_pkg::COL_OUT_W-1:0]       center_col,
  output logic                                frame_last,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lec_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lec_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int RST_LAST_COL =
    ((lec_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : lec_pkg::RESET_WIDTH) - 1;
  localparam int RST_LAST_ROW =
    ((lec_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : lec_pkg::RESET_HEIGHT) - 1;
  localparam int MEM_W = 2 * lec_pkg::PIX_W;

  // configuration, kept as effective size minus one
  logic [lec_pkg::MASK_W-1:0]       mask_sel;
  logic [COL_W-1:0]                 last_col;
  logic [ROW_W-1:0]                 last_row;
  logic [lec_pkg::WIDTH_REG_W-1:0]  wr_width;
  logic [lec_pkg::HEIGHT_REG_W-1:0] wr_height;
  logic [COL_W-1:0]                 last_col_next;
  logic [ROW_W-1:0]                 last_row_next;
  logic                             cfg_wr;
  logic                             size_wr;

  // position of the next pixel
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_m1;
  logic [ROW_W-1:0] row_m1;

  // handshake and pipeline control
  logic pix_acc;
  logic out_free;
  logic s2_valid;
  logic s2_free;
  logic s2_go;
  logic s1_valid;
  logic s1_go;

  // store stage payload
  logic [lec_pkg::PIX_W-1:0] s1_pix;
  logic [COL_W-1:0]          s1_col;
  logic                      s1_emit;
  lec_pkg::tag_t             s1_tag;
  lec_pkg::tag_t             tag_in;

  // line store ports: upper row in the high byte, middle row in the low byte
  logic [MEM_W-1:0] rd_data;
  logic [MEM_W-1:0] wr_data;

  logic signed [lec_pkg::SUM_W-1:0] sum_q;
  lec_pkg::tag_t                    tag_q;
  logic [lec_pkg::PIX_W-1:0]        clamped;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign size_wr   = cfg_wr && (cfg_index == lec_pkg::REG_WIDTH ||
                                cfg_index == lec_pkg::REG_HEIGHT);
  assign wr_width  = cfg_data[lec_pkg::WIDTH_REG_W-1:0];
  assign wr_height = cfg_data[lec_pkg::HEIGHT_REG_W-1:0];

  // saturate the written size to 3..max
  always_comb begin
    if (wr_width < lec_pkg::WIDTH_REG_W'(3)) begin
      last_col_next = COL_W'(2);
    end else if (32'(wr_width) > MAX_WIDTH) begin
      last_col_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col_next = COL_W'(wr_width - 1'b1);
    end
    if (wr_height < lec_pkg::HEIGHT_REG_W'(3)) begin
      last_row_next = ROW_W'(2);
    end else if (32'(wr_height) > MAX_HEIGHT) begin
      last_row_next = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row_next = ROW_W'(wr_height - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_sel <= lec_pkg::MASK_FOUR;
      last_col <= COL_W'(RST_LAST_COL);
      last_row <= ROW_W'(RST_LAST_ROW);
    end else if (cfg_wr) begin
      case (cfg_index)
        lec_pkg::REG_MASK:   mask_sel <= cfg_data[lec_pkg::MASK_W-1:0];
        lec_pkg::REG_WIDTH:  last_col <= last_col_next;
        lec_pkg::REG_HEIGHT: last_row <= last_row_next;
        default: ;
      endcase
    end
  end

  // stall chain: each stage moves when the one after it has room
  assign out_free    = !result_valid || result_ready;
  assign s2_go       = s2_valid && out_free;
  assign s2_free     = !s2_valid || out_free;
  assign s1_go       = s1_valid && s2_free;
  assign pixel_ready = !s1_valid || s1_go;
  assign pix_acc     = pixel_valid && pixel_ready;

  // raster counters, restarted by a size write
  always_ff @(posedge clk) begin
    if (rst || size_wr) begin
      col_count <= '0;
      row_count <= '0;
    end else if (pix_acc) begin
      if (col_count >= last_col) begin
        col_count <= '0;
        row_count <= (row_count >= last_row) ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  assign col_m1 = col_count - 1'b1;
  assign row_m1 = row_count - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  // tag the item with its window centre at acceptance
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_pix      <= pixel;
      s1_col      <= col_count;
      s1_emit     <= (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));
      s1_tag.last <= (row_count == last_row) && (col_count == last_col);
      s1_tag.row  <= lec_pkg::ROW_OUT_W'(row_m1);
      s1_tag.col  <= lec_pkg::COL_OUT_W'(col_m1);
    end
  end

  // read the column entry on acceptance, write it back shifted up one row
  // when the item leaves the store stage; consecutive items touch different
  // columns unless a size write restarts the row, so no forwarding is needed
  assign wr_data = {rd_data[lec_pkg::PIX_W-1:0], s1_pix};

  lec_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W),
    .DW    (MEM_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (pix_acc),
    .rd_addr (col_count),
    .rd_data (rd_data),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  assign tag_in = s1_tag;

  lec_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .shift_en   (s1_go),
    .load_en    (s1_go && s1_emit),
    .mask_sel   (mask_sel),
    .cur_upper  (rd_data[MEM_W-1:lec_pkg::PIX_W]),
    .cur_middle (rd_data[lec_pkg::PIX_W-1:0]),
    .cur_pixel  (s1_pix),
    .tag_in     (tag_in),
    .sum_q      (sum_q),
    .tag_q      (tag_q)
  );

  // only interior centres go on to the sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_go && s1_emit;
    end
  end

  // clamp to 0..255
  always_comb begin
    if (sum_q[lec_pkg::SUM_W-1]) begin
      clamped = '0;
    end else if (|sum_q[lec_pkg::SUM_W-2:lec_pkg::PIX_W]) begin
      clamped = '1;
    end else begin
      clamped = sum_q[lec_pkg::PIX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s2_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      edge_value <= clamped;
      center_row <= tag_q.row;
      center_col <= tag_q.col;
      frame_last <= tag_q.last;
    end
  end

  // checks
  `LEC_ASSERT_SAME(a_no_col_clash, clk, rst, pix_acc && s1_go, col_count != s1_col, "line store read and write hit the same column")
  `LEC_ASSERT_SAME(a_col_in_row, clk, rst, 1'b1, col_count <= last_col, "column counter past row end")
  `LEC_ASSERT_NEXT(a_sum_held, clk, rst, s2_valid && !out_free, s2_valid, "sum stage dropped a stalled item")

endmodule

// ===== design/lec_line_mem.sv =====
// two-row line store, one write and one registered read per cycle
module lec_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/lec_conv.sv =====
// 3x3 window columns and registered mask response
module lec_conv (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               shift_en,
  input  logic                               load_en,
  input  logic [lec_pkg::MASK_W-1:0]         mask_sel,
  input  logic [lec_pkg::PIX_W-1:0]          cur_upper,
  input  logic [lec_pkg::PIX_W-1:0]          cur_middle,
  input  logic [lec_pkg::PIX_W-1:0]          cur_pixel,
  input  lec_pkg::tag_t                      tag_in,
  output logic signed [lec_pkg::SUM_W-1:0]   sum_q,
  output lec_pkg::tag_t                      tag_q
);

  logic [lec_pkg::PIX_W-1:0] win_old [3];
  logic [lec_pkg::PIX_W-1:0] win_mid [3];
  logic [lec_pkg::PIX_W-1:0] cur [3];
  logic signed [lec_pkg::SUM_W-1:0] tap_s [lec_pkg::TAPS];
  logic signed [lec_pkg::SUM_W-1:0] resp [lec_pkg::NUM_MASKS];

  assign cur[0] = cur_upper;
  assign cur[1] = cur_middle;
  assign cur[2] = cur_pixel;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tap_s[r*3]     = $signed({{(lec_pkg::SUM_W-lec_pkg::PIX_W){1'b0}}, win_old[r]});
      tap_s[r*3 + 1] = $signed({{(lec_pkg::SUM_W-lec_pkg::PIX_W){1'b0}}, win_mid[r]});
      tap_s[r*3 + 2] = $signed({{(lec_pkg::SUM_W-lec_pkg::PIX_W){1'b0}}, cur[r]});
    end
  end

  // constant weights per mask, one response per mask then select
  always_comb begin
    for (int m = 0; m < lec_pkg::NUM_MASKS; m++) begin
      resp[m] = '0;
      for (int i = 0; i < lec_pkg::TAPS; i++) begin
        resp[m] = resp[m] + lec_pkg::SUM_W'(lec_pkg::LAP_WEIGHTS[m][i]) * tap_s[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        win_old[r] <= '0;
        win_mid[r] <= '0;
      end
    end else if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_old[r] <= win_mid[r];
        win_mid[r] <= cur[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      sum_q <= resp[mask_sel];
      tag_q <= tag_in;
    end
  end

endmodule
